// ===== src/i2c_master_transaction_sequencer_top_macros.svh =====
// Assertion macros used by the sequencer RTL
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== src/i2cseq_pkg.sv =====
package i2cseq_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    // completion codes
    localparam logic [1:0] FIN_BUSY     = 2'd0;
    localparam logic [1:0] FIN_READ     = 2'd1;
    localparam logic [1:0] FIN_WRITE    = 2'd2;
    localparam logic [1:0] FIN_REJECTED = 2'd3;

    // acknowledge control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // controller status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NAK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

    // clears the read bit of the address
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

    // one result beat, first field in the highest bits
    typedef struct packed {
        logic [7:0] error_code;
        logic [1:0] finish;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       irq_clear;
        logic [1:0] ack_control;
        logic       stop_set;
        logic       start_clear;
        logic       start_set;
        logic [7:0] send_byte;
        logic       send_valid;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== src/i2cseq_ram.sv =====
module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/i2cseq_core.sv =====
module i2cseq_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_disable,
    input  logic                            in_accept,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      dev_addr,
    input  logic [7:0]                      write_length,
    input  logic [7:0]                      read_length,
    input  logic [7:0]                      write_byte,
    input  logic [7:0]                      bus_status,
    input  logic [7:0]                      rx_data,
    output logic                            mem_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_waddr,
    output logic [7:0]                      mem_wdata,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_raddr,
    input  logic [7:0]                      mem_rdata,
    output i2cseq_pkg::result_t             result
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

    logic [7:0]       load_ptr_reg, load_ptr_next;
    logic [7:0]       send_ptr_reg, send_ptr_next;
    logic [IDX_W-1:0] load_idx_reg, load_idx_next;
    logic [IDX_W-1:0] send_idx_reg, send_idx_next;
    logic [7:0]       writes_left_reg, writes_left_next;
    logic [7:0]       reads_left_reg, reads_left_next;
    logic [7:0]       read_ptr_reg, read_ptr_next;
    logic [7:0]       target_reg, target_next;
    logic [7:0]       error_reg, error_next;
    logic             disable_reg;
    logic             byp_valid_reg;
    logic [7:0]       byp_data_reg;
    logic [7:0]       store_byte;
    logic [1:0]       done_code;
    logic [7:0]       reads_dec;

    // store index follows pointer modulo depth; pointer wrap restarts it
    function automatic logic [IDX_W-1:0] idx_step(input logic [7:0] ptr,
                                                  input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (ptr == 8'hFF || idx == IDX_LAST) begin
            r = '0;
        end else begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    // byte at the send pointer, with forwarding of a same-address write
    assign store_byte = byp_valid_reg ? byp_data_reg : mem_rdata;
    assign done_code  = target_reg[0] ? i2cseq_pkg::FIN_READ : i2cseq_pkg::FIN_WRITE;
    assign reads_dec  = (reads_left_reg != 8'd0) ? reads_left_reg - 8'd1 : 8'd0;

    // store write port and lookahead read address
    assign mem_we    = in_accept && (cmd == i2cseq_pkg::CMD_LOAD);
    assign mem_waddr = load_idx_reg;
    assign mem_wdata = write_byte;
    assign mem_raddr = aresetn ? send_idx_next : '0;

    // decode one item
    always_comb begin
        load_ptr_next    = load_ptr_reg;
        send_ptr_next    = send_ptr_reg;
        load_idx_next    = load_idx_reg;
        send_idx_next    = send_idx_reg;
        writes_left_next = writes_left_reg;
        reads_left_next  = reads_left_reg;
        read_ptr_next    = read_ptr_reg;
        target_next      = target_reg;
        error_next       = error_reg;
        result           = '0;

        if (in_accept) begin
            unique case (cmd)
                i2cseq_pkg::CMD_LOAD: begin
                    load_ptr_next = load_ptr_reg + 8'd1;
                    load_idx_next = idx_step(load_ptr_reg, load_idx_reg);
                end
                i2cseq_pkg::CMD_START: begin
                    if (disable_reg) begin
                        result.finish = i2cseq_pkg::FIN_REJECTED;
                    end else begin
                        target_next      = dev_addr;
                        writes_left_next = write_length;
                        reads_left_next  = read_length;
                        load_ptr_next    = 8'd0;
                        load_idx_next    = '0;
                        send_ptr_next    = 8'd0;
                        send_idx_next    = '0;
                        read_ptr_next    = 8'd0;
                        error_next       = 8'd0;
                        result.start_set = 1'b1;
                    end
                end
                i2cseq_pkg::CMD_EVENT: begin
                    unique case (bus_status) inside
                        i2cseq_pkg::ST_START: begin
                            result.send_valid = 1'b1;
                            result.send_byte  = (writes_left_reg == 8'd0)
                                ? (target_reg | 8'd1)
                                : (target_reg & i2cseq_pkg::ADDR_WRITE_MASK);
                            result.irq_clear  = 1'b1;
                        end
                        i2cseq_pkg::ST_RESTART: begin
                            result.send_valid = 1'b1;
                            result.send_byte  = target_reg | 8'd1;
                            result.irq_clear  = 1'b1;
                        end
                        i2cseq_pkg::ST_ADDR_W_ACK,
                        i2cseq_pkg::ST_DATA_W_ACK: begin
                            if (bus_status == i2cseq_pkg::ST_ADDR_W_ACK) begin
                                result.start_clear = 1'b1;
                            end
                            if (writes_left_reg != 8'd0) begin
                                // send next buffered byte
                                result.send_valid = 1'b1;
                                result.send_byte  = store_byte;
                                result.irq_clear  = 1'b1;
                                send_ptr_next     = send_ptr_reg + 8'd1;
                                send_idx_next     = idx_step(send_ptr_reg, send_idx_reg);
                                writes_left_next  = writes_left_reg - 8'd1;
                            end else if (bus_status == i2cseq_pkg::ST_DATA_W_ACK
                                         && target_reg[0]) begin
                                // repeated start into the read phase
                                result.start_set = 1'b1;
                                result.irq_clear = 1'b1;
                            end else if (bus_status == i2cseq_pkg::ST_DATA_W_ACK
                                         || reads_left_reg == 8'd0) begin
                                result.start_clear = 1'b1;
                                result.stop_set    = 1'b1;
                                result.irq_clear   = 1'b1;
                                result.finish      = done_code;
                            end
                        end
                        i2cseq_pkg::ST_ADDR_R_ACK: begin
                            result.start_clear = 1'b1;
                            result.ack_control = (reads_left_reg > 8'd1)
                                ? i2cseq_pkg::ACK_ACK : i2cseq_pkg::ACK_NACK;
                            result.irq_clear   = 1'b1;
                        end
                        i2cseq_pkg::ST_DATA_R_ACK: begin
                            result.rx_valid    = 1'b1;
                            result.rx_byte     = rx_data;
                            result.rx_index    = read_ptr_reg;
                            read_ptr_next      = read_ptr_reg + 8'd1;
                            reads_left_next    = reads_dec;
                            result.ack_control = (reads_dec == 8'd1)
                                ? i2cseq_pkg::ACK_NACK : i2cseq_pkg::ACK_ACK;
                            result.irq_clear   = 1'b1;
                        end
                        i2cseq_pkg::ST_DATA_R_NAK: begin
                            result.rx_valid    = 1'b1;
                            result.rx_byte     = rx_data;
                            result.rx_index    = read_ptr_reg;
                            result.start_clear = 1'b1;
                            result.stop_set    = 1'b1;
                            result.irq_clear   = 1'b1;
                            result.finish      = done_code;
                        end
                        i2cseq_pkg::ST_ARB_LOST: begin
                            // end without STOP
                            error_next    = bus_status;
                            result.finish = done_code;
                        end
                        default: begin
                            // failure: keep the code and stop
                            error_next         = bus_status;
                            result.start_clear = 1'b1;
                            result.stop_set    = 1'b1;
                            result.irq_clear   = 1'b1;
                            result.finish      = done_code;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        result.error_code = error_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg    <= 8'd0;
            send_ptr_reg    <= 8'd0;
            load_idx_reg    <= '0;
            send_idx_reg    <= '0;
            writes_left_reg <= 8'd0;
            reads_left_reg  <= 8'd0;
            read_ptr_reg    <= 8'd0;
            target_reg      <= 8'd0;
            error_reg       <= 8'd0;
            disable_reg     <= 1'b0;
            byp_valid_reg   <= 1'b0;
        end else begin
            load_ptr_reg    <= load_ptr_next;
            send_ptr_reg    <= send_ptr_next;
            load_idx_reg    <= load_idx_next;
            send_idx_reg    <= send_idx_next;
            writes_left_reg <= writes_left_next;
            reads_left_reg  <= reads_left_next;
            read_ptr_reg    <= read_ptr_next;
            target_reg      <= target_next;
            error_reg       <= error_next;
            byp_valid_reg   <= mem_we && (mem_waddr == mem_raddr);
            if (cfg_we) begin
                disable_reg <= cfg_disable;
            end
        end
    end

    // forwarded write data
    always_ff @(posedge aclk) begin
        byp_data_reg <= mem_wdata;
    end

endmodule

// ===== src/i2cseq_skid.sv =====
`include "i2c_master_transaction_sequencer_top_macros.svh"

module i2cseq_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cseq_pkg::result_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cseq_pkg::result_t out_data
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    i2cseq_pkg::result_t out_data_reg, out_data_next;
    i2cseq_pkg::result_t skid_data_reg, skid_data_next;
    logic                accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // refill the output stage from the skid stage first, park when stalled
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_accept_fills, aclk, aresetn, accept, out_valid_reg)
    `ASSERT_NEXT(a_stall_keeps, aclk, aresetn, out_valid_reg && !out_ready, out_valid_reg)
    `ASSERT_NEXT(a_stall_parks, aclk, aresetn, out_valid_reg && !out_ready && accept, skid_valid_reg)

endmodule

// ===== src/i2c_master_transaction_sequencer_top.sv =====
// I2C master transaction sequencer.
// Input channel s_*: one beat per item; s_tuser carries the command (load
// write byte, start transaction, bus status event), s_tdata the fields.
// Result channel m_*: exactly one result beat per accepted item, telling the
// bus controller what to do next (byte to send, START/STOP, ACK/NACK, clear
// interrupt, received byte with index, completion and error code).
// Configuration channel cfg_*: one bit, disable_transfers; always ready.
// The result is registered in the output stage (or first in the skid register)
// before it reaches m_tdata. Throughput: one item per cycle while s_tready is
// high. The write buffer is a RAM with registered read, addressed ahead by the next
// send index, with a forwarding register for a load to the same entry.
// A two-entry output stage (result register plus skid register) keeps input
// accepted while a result waits; s_tready drops only when both are full, i.e.
// after the receiver has stalled with one result parked.
// Reset (aresetn low, synchronous) clears all pointers, counters, the saved
// error and the disable bit; buffer contents stay undefined until loaded.
module i2c_master_transaction_sequencer_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] dev_addr, [15:8] write_length, [23:16] read_length,
    // [31:24] write_byte, [39:32] bus_status, [47:40] rx_data
    input  logic [47:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] send_valid, [8:1] send_byte, [9] start_set, [10] start_clear,
    // [11] stop_set, [13:12] ack_control, [14] irq_clear, [15] rx_valid,
    // [23:16] rx_byte, [31:24] rx_index, [33:32] finish, [41:34] error_code,
    // [47:42] zero
    output logic [i2cseq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic                in_accept;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    i2cseq_pkg::result_t core_result;
    i2cseq_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    i2cseq_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    i2cseq_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_disable (cfg_data),
        .in_accept   (in_accept),
        .cmd         (s_tuser),
        .dev_addr    (s_tdata[7:0]),
        .write_length(s_tdata[15:8]),
        .read_length (s_tdata[23:16]),
        .write_byte  (s_tdata[31:24]),
        .bus_status  (s_tdata[39:32]),
        .rx_data     (s_tdata[47:40]),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .result      (core_result)
    );

    i2cseq_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (core_result),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_result)
    );

    // pack result, pad to whole bytes
    assign m_tdata = i2cseq_pkg::M_DATA_W'(out_result);

endmodule
